FILE: hdl/saa_pkg.sv
// Package: shared types, sizes and codes of the stack arena allocator
package saa_pkg;

    // Sizes
    localparam int STACK_DEPTH = 64;
    localparam int CAP_BITS    = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W       = 17;
    localparam int ADDR_W      = 32;

    // Largest usable arena
    localparam logic [LVL_W-1:0] CAP_LIM = LVL_W'(64'd1 << CAP_BITS);

    // Arena modes
    localparam logic MODE_FIXED    = 1'b0;
    localparam logic MODE_CIRCULAR = 1'b1;

    // Operations
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE_AD = 2'd1;
    localparam logic [1:0] OP_FREE_N  = 2'd2;
    localparam logic [1:0] OP_REALLOC = 2'd3;

    // Status codes
    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_ZERO  = 3'd1;
    localparam logic [2:0] STAT_SPACE = 3'd2;
    localparam logic [2:0] STAT_FULL  = 3'd3;
    localparam logic [2:0] STAT_UNDER = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_CAP   = 2'd1;
    localparam logic [1:0] REG_ALIGN = 2'd2;
    localparam logic [1:0] REG_BASE  = 2'd3;

    // Input beat
    typedef struct packed {
        logic [1:0]        operation;
        logic [LVL_W-1:0]  size;
        logic [ADDR_W-1:0] address;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              released;
        logic [2:0]        status;
        logic [LVL_W-1:0]  fill_level;
    } t_out;

endpackage

FILE: hdl/stack_arena_allocator.sv
// Top level: stack arena bump allocator, size stack kept in a RAM
// Steps from input beat to result valid: stack top read, then, for an allocation,
// fit check, alignment and push; the frees and a zero size request stop after the
// top read, a refused allocation after the fit check; the result waits while the
// result register is stalled. Throughput: one item at a time. Reset (synchronous,
// active low) empties the arena and the stack and loads the register reset values;
// stack RAM contents are not cleared.
module stack_arena_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  saa_pkg::t_in         i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output saa_pkg::t_out        o_out
);

    import saa_pkg::*;

    // State codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_ALC1 = 3'd2;
    localparam logic [2:0] S_ALC2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Configuration
    logic              r_mode;
    logic [LVL_W-1:0]  r_capacity;
    logic [2:0]        r_align;
    logic [ADDR_W-1:0] r_base;

    // Control and arena state
    logic [2:0]        r_state, n_state;
    logic [LVL_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // Per-item payload
    logic [1:0]        r_op;
    logic [LVL_W-1:0]  r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [LVL_W-1:0]  r_start, n_start;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic              r_rel, n_rel;
    logic [2:0]        r_s2, n_s2;
    logic              r_retry, n_retry;
    t_out              r_res, n_res;
    t_out              r_out, n_out;

    // RAM ports
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [LVL_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [LVL_W-1:0]  ram_rd_data;

    // Datapath
    logic [LVL_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] top_addr;
    logic              top_match;
    logic              pop_under;
    logic [LVL_W-1:0]  pop_used;
    logic [LVL_W:0]    sum_lvl;
    logic              over;
    logic              wrap_fit;
    logic [6:0]        amask;
    logic [LVL_W:0]    rounded;
    logic [LVL_W-1:0]  lvl_fin;
    logic [LVL_W-1:0]  push_sz;
    logic [ADDR_W-1:0] blk;

    saa_ram #(
        .WIDTH (LVL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Arena size clipped to the largest supported
    assign eff_cap = (r_capacity > CAP_LIM) ? CAP_LIM : r_capacity;

    // Stack top read at accept
    assign cnt_m1      = r_count - CNT_W'(1);
    assign ram_rd_en   = i_in_valid && o_in_ready;
    assign ram_rd_addr = cnt_m1[IDX_W-1:0];

    // Top block check and pop, valid in S_TOP
    assign top_addr  = r_base + ADDR_W'(r_used) - ADDR_W'(ram_rd_data);
    assign top_match = (r_count != '0) && (top_addr == r_addr);
    assign pop_under = ram_rd_data > r_used;
    assign pop_used  = pop_under ? '0 : (r_used - ram_rd_data);

    // Fit check, valid in S_ALC1
    assign sum_lvl  = {1'b0, r_used} + {1'b0, r_size};
    assign over     = sum_lvl > {1'b0, eff_cap};
    assign wrap_fit = (r_mode == MODE_CIRCULAR) && (r_size <= eff_cap);

    // Alignment and push size, valid in S_ALC2
    assign amask   = 7'((8'd1 << r_align) - 8'd1);
    assign rounded = ({1'b0, r_lvl} + (LVL_W+1)'(amask)) & ~((LVL_W+1)'(amask));
    assign lvl_fin = (rounded > {1'b0, eff_cap}) ? eff_cap : rounded[LVL_W-1:0];
    assign push_sz = lvl_fin - r_start;
    assign blk     = r_base + ADDR_W'(r_start);

    assign ram_wr_addr = r_count[IDX_W-1:0];
    assign ram_wr_data = push_sz;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_count     = r_count;
        n_start     = r_start;
        n_lvl       = r_lvl;
        n_rel       = r_rel;
        n_s2        = r_s2;
        n_retry     = r_retry;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_wr_en   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rel   = 1'b0;
                    n_s2    = STAT_OK;
                    n_retry = 1'b0;
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                n_res.block_address = '0;
                n_res.released      = 1'b0;
                n_res.status        = STAT_OK;
                n_res.fill_level    = r_used;
                case (r_op)
                    OP_FREE_AD: begin
                        if (top_match) begin
                            n_count             = cnt_m1;
                            n_used              = pop_used;
                            n_res.released      = 1'b1;
                            n_res.status        = pop_under ? STAT_UNDER : STAT_OK;
                            n_res.fill_level    = pop_used;
                        end
                        n_state = S_DONE;
                    end
                    OP_FREE_N: begin
                        if (r_size > r_used) begin
                            n_used           = '0;
                            n_res.status     = STAT_UNDER;
                            n_res.fill_level = '0;
                        end else begin
                            n_used           = r_used - r_size;
                            n_res.fill_level = r_used - r_size;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        // allocate or reallocate
                        if (r_size == '0) begin
                            n_res.status = STAT_ZERO;
                            n_state      = S_DONE;
                        end else begin
                            if (r_op == OP_REALLOC) begin
                                if (top_match) begin
                                    n_count = cnt_m1;
                                    n_used  = pop_used;
                                    n_rel   = 1'b1;
                                    n_s2    = pop_under ? STAT_UNDER : STAT_OK;
                                end else begin
                                    n_retry = 1'b1;
                                end
                            end
                            n_state = S_ALC1;
                        end
                    end
                endcase
            end
            S_ALC1: begin
                n_res.block_address = '0;
                n_res.released      = r_rel;
                n_res.fill_level    = r_used;
                n_res.status        = STAT_OK;
                if (over && !wrap_fit) begin
                    n_res.status = STAT_SPACE;
                    n_state      = S_DONE;
                end else if (r_count >= CNT_W'(STACK_DEPTH)) begin
                    n_res.status = STAT_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_start = over ? '0 : r_used;
                    n_lvl   = over ? r_size : sum_lvl[LVL_W-1:0];
                    n_state = S_ALC2;
                end
            end
            S_ALC2: begin
                n_res.block_address = blk;
                if (r_retry && (blk == r_addr)) begin
                    // new block landed on the named address: free it again
                    n_used           = r_start;
                    n_res.released   = 1'b1;
                    n_res.status     = STAT_OK;
                    n_res.fill_level = r_start;
                end else begin
                    ram_wr_en        = 1'b1;
                    n_count          = r_count + CNT_W'(1);
                    n_used           = lvl_fin;
                    n_res.released   = r_rel;
                    n_res.status     = r_s2;
                    n_res.fill_level = lvl_fin;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FIXED;
            r_capacity <= CAP_LIM;
            r_align    <= 3'd3;
            r_base     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode     <= i_cfg_data[0];
                REG_CAP:   r_capacity <= i_cfg_data[LVL_W-1:0];
                REG_ALIGN: r_align    <= i_cfg_data[2:0];
                REG_BASE:  r_base     <= i_cfg_data;
                default:   r_base     <= r_base;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ram_rd_en) begin
            r_op   <= i_in.operation;
            r_size <= i_in.size;
            r_addr <= i_in.address;
        end
        r_start <= n_start;
        r_lvl   <= n_lvl;
        r_rel   <= n_rel;
        r_s2    <= n_s2;
        r_retry <= n_retry;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

FILE: hdl/saa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module saa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/saa_checker.sv
// Port checker for the stack arena allocator, bound to the top level
module saa_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_ready,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  saa_pkg::t_out o_out
);

    import saa_pkg::*;

    // Items taken but not yet delivered
    logic [1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(i_in_valid && o_in_ready) - 2'(o_out_valid && i_out_ready);
        end
    end

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // Every result beat answers an accepted input beat
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |-> r_pend != 2'd0)
        else $error("result beat without an input beat");

    // A refused allocation hands out no block
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == STAT_ZERO || o_out.status == STAT_SPACE
            || o_out.status == STAT_FULL) |-> o_out.block_address == '0)
        else $error("refused allocation returned an address");

    // A zero size request pops nothing
    a_zero_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == STAT_ZERO |-> !o_out.released)
        else $error("zero size request released a block");

    // Fill level stays within the largest supported arena
    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.fill_level <= CAP_LIM)
        else $error("fill level beyond arena");

endmodule

bind stack_arena_allocator saa_checker u_saa_checker (.*);
